// ===== design/cprd_pkg.sv =====
// ----------------------------------------------------------------------------
// cprd_pkg: shared types and constants for the camera primary ray block
// Field widths, register index codes and default fixed-point formats.
// ----------------------------------------------------------------------------
package cprd_pkg;

   // default fixed-point formats
   localparam int FRAC_BITS_DEF     = 16;
   localparam int SUBPIXEL_BITS_DEF = 8;

   // field widths
   localparam int SIZE_W     = 13;   // image width / height
   localparam int COEF_W     = 20;   // aspect ratio, fov tangent (unsigned)
   localparam int DIR_W      = 18;   // direction components (signed)
   localparam int POS_W      = 20;   // sample position
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // screen offset saturation, magnitude 2^34 - 1
   localparam int PXY_W = 34;

   // normalized magnitudes keep their msb at bit 27
   localparam int NORM_W   = 28;
   localparam int NORM_MSB = 27;

   // output saturation limits
   localparam int OUT_MAX = 131071;
   localparam int OUT_MIN_MAG = 131072;

   // register index codes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_ASPECT_RATIO = 3'd2,
      CSR_FOV_TANGENT  = 3'd3,
      CSR_VIEW_DIR_X   = 3'd4,
      CSR_VIEW_DIR_Y   = 3'd5,
      CSR_VIEW_DIR_Z   = 3'd6
   } csr_index_type;

endpackage

// ===== design/camera_primary_ray_direction_top.sv =====
// ----------------------------------------------------------------------------
// camera_primary_ray_direction_top: pinhole camera primary ray direction
// Maps one subpixel sample to the unit direction of the camera ray through it.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle while no result waits. The latency is
// set by the two pixel-to-screen dividers and the per-component dividers,
// which resolve one quotient bit per stage, and by the square root, which
// resolves one root bit per stage. A stalled result holds the whole pipeline;
// nothing is dropped. Configuration is written through the csr_ port and is
// accepted every cycle; write it only while no item is in flight.
module camera_primary_ray_direction_top
   import cprd_pkg::*;
#(
   parameter int FRAC_BITS     = FRAC_BITS_DEF,
   parameter int SUBPIXEL_BITS = SUBPIXEL_BITS_DEF
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [POS_W-1:0]        req_sample_x,
   input  logic [POS_W-1:0]        req_sample_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [DIR_W-1:0] rsp_ray_dir_x,
   output logic signed [DIR_W-1:0] rsp_ray_dir_y,
   output logic signed [DIR_W-1:0] rsp_ray_dir_z,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int F   = FRAC_BITS;
   localparam int S   = SUBPIXEL_BITS;
   localparam int NW  = POS_W + F + 1;           // mapping dividend
   localparam int DW  = SIZE_W + S;              // mapping divisor
   localparam int UW  = F + 15;                  // |u| <= 2^(F+14)
   localparam int AW  = UW + COEF_W;
   localparam int TW  = AW - F;
   localparam int BW  = TW + COEF_W;
   localparam int RM  = (F > 17) ? F : 17;
   localparam int CMW = ((RM + 1) > (19 + RM - F)) ? (RM + 1) : (19 + RM - F);
   localparam int PRW = CMW + PXY_W - F;
   localparam int SW  = PRW + 3;                 // signed sum
   localparam int MW  = SW - 1;                  // sum magnitude
   localparam int PBW = $clog2(MW);
   localparam int SQW = 2 * NORM_W + 2;
   localparam int RTW = SQW + 1;
   localparam int SQN = NORM_W + 1;              // root bits
   localparam int LW  = NORM_W + 1;              // root width
   localparam int QN  = F + 1;                   // component quotient bits

   localparam logic [NW-1:0]      QMAX    = NW'(1) << (F + 14);
   localparam logic [NW-1:0]      ONE_Q   = NW'(1) << F;
   localparam logic [BW-F-1:0]    PXY_MAXB = (BW-F)'((64'd1 << PXY_W) - 64'd1);
   localparam logic [TW-1:0]      PXY_MAXT = TW'((64'd1 << PXY_W) - 64'd1);

   // global advance: the pipeline moves unless a result waits
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // ------------------------------------------------------------------ config
   logic [SIZE_W-1:0]       wid_ff, hgt_ff;
   logic [COEF_W-1:0]       asp_ff, fov_ff;
   logic signed [DIR_W-1:0] vdx_ff, vdy_ff, vdz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff <= SIZE_W'(640);
         hgt_ff <= SIZE_W'(480);
         asp_ff <= COEF_W'(87381);
         fov_ff <= COEF_W'(65536);
         vdx_ff <= '0;
         vdy_ff <= '0;
         vdz_ff <= DIR_W'(65536);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  wid_ff <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT: hgt_ff <= csr_wdata[SIZE_W-1:0];
            CSR_ASPECT_RATIO: asp_ff <= csr_wdata[COEF_W-1:0];
            CSR_FOV_TANGENT:  fov_ff <= csr_wdata[COEF_W-1:0];
            CSR_VIEW_DIR_X:   vdx_ff <= signed'(csr_wdata[DIR_W-1:0]);
            CSR_VIEW_DIR_Y:   vdy_ff <= signed'(csr_wdata[DIR_W-1:0]);
            CSR_VIEW_DIR_Z:   vdz_ff <= signed'(csr_wdata[DIR_W-1:0]);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------ camera basis (from config)
   // right = (-dz, 0, dx) or (1,0,0); down = dir x right; kept as sign/magnitude
   logic [CMW-1:0] c_r0m_ff, c_r2m_ff, c_d0m_ff, c_d1m_ff, c_d2m_ff;
   logic [CMW-1:0] c_r0m_in, c_r2m_in, c_d0m_in, c_d1m_in, c_d2m_in;
   logic           c_r0n_ff, c_r2n_ff, c_d0n_ff, c_d1n_ff, c_d2n_ff;
   logic           c_r0n_in, c_r2n_in, c_d0n_in, c_d1n_in, c_d2n_in;

   always_comb begin
      logic                       axis;
      logic [DIR_W-1:0]           dxm, dym, dzm;
      logic [DIR_W+CMW-1:0]       p_a, p_b, p_c, p_d;
      logic signed [CMW+1:0]      ta, tb, diff;
      axis = (vdx_ff == '0) && (vdz_ff == '0);
      dxm  = vdx_ff[DIR_W-1] ? DIR_W'(-vdx_ff) : DIR_W'(vdx_ff);
      dym  = vdy_ff[DIR_W-1] ? DIR_W'(-vdy_ff) : DIR_W'(vdy_ff);
      dzm  = vdz_ff[DIR_W-1] ? DIR_W'(-vdz_ff) : DIR_W'(vdz_ff);
      if (axis) begin
         c_r0m_in = CMW'(1) << F;
         c_r0n_in = 1'b0;
         c_r2m_in = '0;
         c_r2n_in = 1'b0;
      end else begin
         c_r0m_in = CMW'(dzm);
         c_r0n_in = !vdz_ff[DIR_W-1];
         c_r2m_in = CMW'(dxm);
         c_r2n_in = vdx_ff[DIR_W-1];
      end
      // dn0 = dy*r2
      p_a = (DIR_W+CMW)'(dym) * (DIR_W+CMW)'(c_r2m_in);
      c_d0m_in = CMW'(p_a >> F);
      c_d0n_in = vdy_ff[DIR_W-1] ^ c_r2n_in;
      // dn2 = -(dy*r0)
      p_b = (DIR_W+CMW)'(dym) * (DIR_W+CMW)'(c_r0m_in);
      c_d2m_in = CMW'(p_b >> F);
      c_d2n_in = !(vdy_ff[DIR_W-1] ^ c_r0n_in);
      // dn1 = dz*r0 - dx*r2
      p_c = (DIR_W+CMW)'(dzm) * (DIR_W+CMW)'(c_r0m_in);
      p_d = (DIR_W+CMW)'(dxm) * (DIR_W+CMW)'(c_r2m_in);
      ta = signed'((CMW+2)'(CMW'(p_c >> F)));
      tb = signed'((CMW+2)'(CMW'(p_d >> F)));
      if (vdz_ff[DIR_W-1] ^ c_r0n_in) ta = -ta;
      if (vdx_ff[DIR_W-1] ^ c_r2n_in) tb = -tb;
      diff = ta - tb;
      c_d1n_in = diff[CMW+1];
      c_d1m_in = diff[CMW+1] ? CMW'(-diff) : CMW'(diff);
   end

   always_ff @(posedge clock) begin
      c_r0m_ff <= c_r0m_in; c_r0n_ff <= c_r0n_in;
      c_r2m_ff <= c_r2m_in; c_r2n_ff <= c_r2n_in;
      c_d0m_ff <= c_d0m_in; c_d0n_ff <= c_d0n_in;
      c_d1m_ff <= c_d1m_in; c_d1n_ff <= c_d1n_in;
      c_d2m_ff <= c_d2m_in; c_d2n_ff <= c_d2n_in;
   end

   // --------------------------------------------- pixel to screen dividers
   // restoring division, one quotient bit per stage, quotient shifts into num
   logic [DW-1:0] divx, divy;
   assign divx = DW'((wid_ff == '0) ? SIZE_W'(1) : wid_ff) << S;
   assign divy = DW'((hgt_ff == '0) ? SIZE_W'(1) : hgt_ff) << S;

   logic          mv_ff  [0:NW];
   logic          mv_in  [0:NW];
   logic [NW-1:0] mxn_ff [0:NW], myn_ff [0:NW];
   logic [NW-1:0] mxn_in [0:NW], myn_in [0:NW];
   logic [DW-1:0] mxr_ff [0:NW], myr_ff [0:NW];
   logic [DW-1:0] mxr_in [0:NW], myr_in [0:NW];

   always_comb begin
      logic [DW:0] tx, ty;
      mv_in[0]  = req_valid;
      mxn_in[0] = NW'(req_sample_x) << (F + 1);
      myn_in[0] = NW'(req_sample_y) << (F + 1);
      mxr_in[0] = '0;
      myr_in[0] = '0;
      for (int k = 0; k < NW; k++) begin
         mv_in[k+1] = mv_ff[k];
         tx = {mxr_ff[k], mxn_ff[k][NW-1]};
         ty = {myr_ff[k], myn_ff[k][NW-1]};
         if (tx >= {1'b0, divx}) begin
            mxr_in[k+1] = DW'(tx - {1'b0, divx});
            mxn_in[k+1] = {mxn_ff[k][NW-2:0], 1'b1};
         end else begin
            mxr_in[k+1] = tx[DW-1:0];
            mxn_in[k+1] = {mxn_ff[k][NW-2:0], 1'b0};
         end
         if (ty >= {1'b0, divy}) begin
            myr_in[k+1] = DW'(ty - {1'b0, divy});
            myn_in[k+1] = {myn_ff[k][NW-2:0], 1'b1};
         end else begin
            myr_in[k+1] = ty[DW-1:0];
            myn_in[k+1] = {myn_ff[k][NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NW; k++) mv_ff[k] <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k <= NW; k++) mv_ff[k] <= mv_in[k];
      end
      if (adv) begin
         for (int k = 0; k <= NW; k++) begin
            mxn_ff[k] <= mxn_in[k]; myn_ff[k] <= myn_in[k];
            mxr_ff[k] <= mxr_in[k]; myr_ff[k] <= myr_in[k];
         end
      end
   end

   // --------------------------------------------------- screen offsets
   logic             e1_v_ff, e2_v_ff, e3_v_ff, e4_v_ff, e5_v_ff, e6_v_ff;
   logic             e7_v_ff, e8_v_ff, e9_v_ff, e10_v_ff;
   logic [UW-1:0]    e1_um_ff, e1_vm_ff, e1_um_in, e1_vm_in;
   logic             e1_un_ff, e1_vn_ff, e1_un_in, e1_vn_in;
   logic [AW-1:0]    e2_pa_ff, e2_pv_ff;
   logic             e2_un_ff, e2_vn_ff, e3_un_ff, e3_vn_ff, e4_un_ff, e4_vn_ff;
   logic [BW-1:0]    e3_pb_ff;
   logic [TW-1:0]    e3_py_ff;
   logic [PXY_W-1:0] e4_px_ff, e4_py_ff, e4_px_in, e4_py_in;

   // u = q - 1 after clamping q, as sign and magnitude
   always_comb begin
      logic [NW-1:0] qx, qy;
      qx = (mxn_ff[NW] > QMAX) ? QMAX : mxn_ff[NW];
      qy = (myn_ff[NW] > QMAX) ? QMAX : myn_ff[NW];
      e1_un_in = qx < ONE_Q;
      e1_vn_in = qy < ONE_Q;
      e1_um_in = e1_un_in ? UW'(ONE_Q - qx) : UW'(qx - ONE_Q);
      e1_vm_in = e1_vn_in ? UW'(ONE_Q - qy) : UW'(qy - ONE_Q);
   end

   // saturate px, py
   always_comb begin
      logic [BW-F-1:0] pxr;
      pxr      = (BW-F)'(e3_pb_ff >> F);
      e4_px_in = (pxr > PXY_MAXB) ? PXY_W'(PXY_MAXB) : PXY_W'(pxr);
      e4_py_in = (e3_py_ff > PXY_MAXT) ? PXY_W'(PXY_MAXT) : PXY_W'(e3_py_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_um_ff <= e1_um_in; e1_vm_ff <= e1_vm_in;
         e1_un_ff <= e1_un_in; e1_vn_ff <= e1_vn_in;
         e2_pa_ff <= AW'(e1_um_ff) * AW'(asp_ff);
         e2_pv_ff <= AW'(e1_vm_ff) * AW'(fov_ff);
         e2_un_ff <= e1_un_ff; e2_vn_ff <= e1_vn_ff;
         e3_pb_ff <= BW'(TW'(e2_pa_ff >> F)) * BW'(fov_ff);
         e3_py_ff <= TW'(e2_pv_ff >> F);
         e3_un_ff <= e2_un_ff; e3_vn_ff <= e2_vn_ff;
         e4_px_ff <= e4_px_in; e4_py_ff <= e4_py_in;
         e4_un_ff <= e3_un_ff; e4_vn_ff <= e3_vn_ff;
      end
   end

   // ------------------------------------------- basis products and sum
   logic [PRW-1:0]        e5_p_ff [0:4];
   logic [PRW-1:0]        e5_p_in [0:4];
   logic [4:0]            e5_n_ff, e5_n_in;
   logic signed [SW-1:0]  e6_s_ff [0:2];
   logic signed [SW-1:0]  e6_s_in [0:2];

   function automatic logic signed [SW-1:0] apply_sign(input logic [PRW-1:0] m,
                                                        input logic n);
      logic signed [SW-1:0] t;
      t = signed'(SW'(m));
      return n ? -t : t;
   endfunction

   always_comb begin
      logic [CMW+PXY_W-1:0] t0, t1, t2, t3, t4;
      t0 = (CMW+PXY_W)'(c_r0m_ff) * (CMW+PXY_W)'(e4_px_ff);
      t1 = (CMW+PXY_W)'(c_d0m_ff) * (CMW+PXY_W)'(e4_py_ff);
      t2 = (CMW+PXY_W)'(c_d1m_ff) * (CMW+PXY_W)'(e4_py_ff);
      t3 = (CMW+PXY_W)'(c_r2m_ff) * (CMW+PXY_W)'(e4_px_ff);
      t4 = (CMW+PXY_W)'(c_d2m_ff) * (CMW+PXY_W)'(e4_py_ff);
      e5_p_in[0] = PRW'(t0 >> F);
      e5_p_in[1] = PRW'(t1 >> F);
      e5_p_in[2] = PRW'(t2 >> F);
      e5_p_in[3] = PRW'(t3 >> F);
      e5_p_in[4] = PRW'(t4 >> F);
      e5_n_in = {c_d2n_ff ^ e4_vn_ff, c_r2n_ff ^ e4_un_ff, c_d1n_ff ^ e4_vn_ff,
                 c_d0n_ff ^ e4_vn_ff, c_r0n_ff ^ e4_un_ff};
      e6_s_in[0] = apply_sign(e5_p_ff[0], e5_n_ff[0])
                 + apply_sign(e5_p_ff[1], e5_n_ff[1]) + SW'(vdx_ff);
      e6_s_in[1] = apply_sign(e5_p_ff[2], e5_n_ff[2]) + SW'(vdy_ff);
      e6_s_in[2] = apply_sign(e5_p_ff[3], e5_n_ff[3])
                 + apply_sign(e5_p_ff[4], e5_n_ff[4]) + SW'(vdz_ff);
   end

   // --------------------------------------------- normalize magnitudes
   logic [MW-1:0]     e7_m_ff [0:2];
   logic [2:0]        e7_n_ff, e8_n_ff, e9_n_ff, e10_n_ff;
   logic [MW-1:0]     e8_m_ff [0:2];
   logic [PBW-1:0]    e8_pos_ff, e8_pos_in;
   logic              e8_z_ff, e8_z_in, e9_z_ff, e10_z_ff;
   logic [NORM_W-1:0] e9_m_ff [0:2];
   logic [NORM_W-1:0] e9_m_in [0:2];
   logic [NORM_W-1:0] e10_m_ff [0:2];
   logic [2*NORM_W-1:0] e10_q_ff [0:2];

   // msb of the largest magnitude is the msb of their OR
   always_comb begin
      logic [MW-1:0] orv;
      orv = e7_m_ff[0] | e7_m_ff[1] | e7_m_ff[2];
      e8_z_in   = (orv == '0);
      e8_pos_in = '0;
      for (int b = 0; b < MW; b++) begin
         if (orv[b]) e8_pos_in = PBW'(b);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (e8_pos_ff >= PBW'(NORM_MSB)) begin
            e9_m_in[i] = NORM_W'(e8_m_ff[i] >> (e8_pos_ff - PBW'(NORM_MSB)));
         end else begin
            e9_m_in[i] = NORM_W'(e8_m_ff[i] << (PBW'(NORM_MSB) - e8_pos_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 5; i++) e5_p_ff[i] <= e5_p_in[i];
         e5_n_ff <= e5_n_in;
         for (int i = 0; i < 3; i++) begin
            e6_s_ff[i] <= e6_s_in[i];
            e7_m_ff[i] <= e6_s_ff[i][SW-1] ? MW'(-e6_s_ff[i]) : MW'(e6_s_ff[i]);
            e7_n_ff[i] <= e6_s_ff[i][SW-1];
            e8_m_ff[i] <= e7_m_ff[i];
            e9_m_ff[i] <= e9_m_in[i];
            e10_m_ff[i] <= e9_m_ff[i];
            e10_q_ff[i] <= (2*NORM_W)'(e9_m_ff[i]) * (2*NORM_W)'(e9_m_ff[i]);
         end
         e8_n_ff   <= e7_n_ff;  e9_n_ff  <= e8_n_ff;  e10_n_ff <= e9_n_ff;
         e8_pos_ff <= e8_pos_in;
         e8_z_ff   <= e8_z_in;  e9_z_ff  <= e8_z_ff;  e10_z_ff <= e9_z_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_v_ff <= 1'b0; e2_v_ff <= 1'b0; e3_v_ff <= 1'b0; e4_v_ff <= 1'b0;
         e5_v_ff <= 1'b0; e6_v_ff <= 1'b0; e7_v_ff <= 1'b0; e8_v_ff <= 1'b0;
         e9_v_ff <= 1'b0; e10_v_ff <= 1'b0;
      end else if (adv) begin
         e1_v_ff <= mv_ff[NW]; e2_v_ff <= e1_v_ff; e3_v_ff <= e2_v_ff;
         e4_v_ff <= e3_v_ff;   e5_v_ff <= e4_v_ff; e6_v_ff <= e5_v_ff;
         e7_v_ff <= e6_v_ff;   e8_v_ff <= e7_v_ff; e9_v_ff <= e8_v_ff;
         e10_v_ff <= e9_v_ff;
      end
   end

   // ------------------------------------------------------- square root
   // digit-by-digit, one root bit per stage
   logic              sv_ff [0:SQN];
   logic              sv_in [0:SQN];
   logic [RTW-1:0]    sn_ff [0:SQN], sr_ff [0:SQN];
   logic [RTW-1:0]    sn_in [0:SQN], sr_in [0:SQN];
   logic [NORM_W-1:0] sm_ff [0:SQN][0:2];
   logic [NORM_W-1:0] sm_in [0:SQN][0:2];
   logic [2:0]        sg_ff [0:SQN], sg_in [0:SQN];
   logic              sz_ff [0:SQN], sz_in [0:SQN];

   always_comb begin
      logic [RTW-1:0] bitv, trial;
      sv_in[0] = e10_v_ff;
      sn_in[0] = RTW'(e10_q_ff[0]) + RTW'(e10_q_ff[1]) + RTW'(e10_q_ff[2]);
      sr_in[0] = '0;
      for (int i = 0; i < 3; i++) sm_in[0][i] = e10_m_ff[i];
      sg_in[0] = e10_n_ff;
      sz_in[0] = e10_z_ff;
      for (int j = 0; j < SQN; j++) begin
         bitv  = RTW'(1) << (2 * (SQN - 1 - j));
         trial = sr_ff[j] + bitv;
         sv_in[j+1] = sv_ff[j];
         if (sn_ff[j] >= trial) begin
            sn_in[j+1] = sn_ff[j] - trial;
            sr_in[j+1] = (sr_ff[j] >> 1) + bitv;
         end else begin
            sn_in[j+1] = sn_ff[j];
            sr_in[j+1] = sr_ff[j] >> 1;
         end
         for (int i = 0; i < 3; i++) sm_in[j+1][i] = sm_ff[j][i];
         sg_in[j+1] = sg_ff[j];
         sz_in[j+1] = sz_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= SQN; j++) sv_ff[j] <= 1'b0;
      end else if (adv) begin
         for (int j = 0; j <= SQN; j++) sv_ff[j] <= sv_in[j];
      end
      if (adv) begin
         for (int j = 0; j <= SQN; j++) begin
            sn_ff[j] <= sn_in[j];
            sr_ff[j] <= sr_in[j];
            for (int i = 0; i < 3; i++) sm_ff[j][i] <= sm_in[j][i];
            sg_ff[j] <= sg_in[j];
            sz_ff[j] <= sz_in[j];
         end
      end
   end

   // ------------------------------------------- component dividers
   // quotient is at most 2^F, so only F+1 bits are resolved
   logic          dv_ff [0:QN], dv_in [0:QN];
   logic [LW-1:0] dlen_ff [0:QN], dlen_in [0:QN];
   logic [LW-1:0] dr_ff [0:QN][0:2], dr_in [0:QN][0:2];
   logic [QN-1:0] dq_ff [0:QN][0:2], dq_in [0:QN][0:2];
   logic [2:0]    dl_ff [0:QN], dl_in [0:QN];
   logic [2:0]    dg_ff [0:QN], dg_in [0:QN];
   logic          dz_ff [0:QN], dz_in [0:QN];

   always_comb begin
      logic [LW:0] t;
      logic        nb;
      dv_in[0]   = sv_ff[SQN];
      dlen_in[0] = (sr_ff[SQN][LW-1:0] == '0) ? LW'(1) : sr_ff[SQN][LW-1:0];
      for (int i = 0; i < 3; i++) begin
         dr_in[0][i] = LW'(sm_ff[SQN][i] >> 1);
         dq_in[0][i] = '0;
         dl_in[0][i] = sm_ff[SQN][i][0];
      end
      dg_in[0] = sg_ff[SQN];
      dz_in[0] = sz_ff[SQN];
      for (int j = 0; j < QN; j++) begin
         dv_in[j+1]   = dv_ff[j];
         dlen_in[j+1] = dlen_ff[j];
         dl_in[j+1]   = dl_ff[j];
         dg_in[j+1]   = dg_ff[j];
         dz_in[j+1]   = dz_ff[j];
         for (int i = 0; i < 3; i++) begin
            nb = (j == 0) ? dl_ff[j][i] : 1'b0;
            t  = {dr_ff[j][i], nb};
            if (t >= {1'b0, dlen_ff[j]}) begin
               dr_in[j+1][i] = LW'(t - {1'b0, dlen_ff[j]});
               dq_in[j+1][i] = {dq_ff[j][i][QN-2:0], 1'b1};
            end else begin
               dr_in[j+1][i] = t[LW-1:0];
               dq_in[j+1][i] = {dq_ff[j][i][QN-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QN; j++) dv_ff[j] <= 1'b0;
      end else if (adv) begin
         for (int j = 0; j <= QN; j++) dv_ff[j] <= dv_in[j];
      end
      if (adv) begin
         for (int j = 0; j <= QN; j++) begin
            dlen_ff[j] <= dlen_in[j];
            dl_ff[j]   <= dl_in[j];
            dg_ff[j]   <= dg_in[j];
            dz_ff[j]   <= dz_in[j];
            for (int i = 0; i < 3; i++) begin
               dr_ff[j][i] <= dr_in[j][i];
               dq_ff[j][i] <= dq_in[j][i];
            end
         end
      end
   end

   // ------------------------------------------------------- result register
   logic                    rv_ff;
   logic signed [DIR_W-1:0] ro_ff [0:2];
   logic signed [DIR_W-1:0] ro_in [0:2];

   always_comb begin
      logic [QN+1:0] q;
      for (int i = 0; i < 3; i++) begin
         q = (QN+2)'(dq_ff[QN][i]);
         if (dz_ff[QN]) begin
            ro_in[i] = '0;
         end else if (dg_ff[QN][i]) begin
            ro_in[i] = (q > (QN+2)'(OUT_MIN_MAG)) ? DIR_W'(-OUT_MIN_MAG)
                                                 : DIR_W'(-signed'(q));
         end else begin
            ro_in[i] = (q > (QN+2)'(OUT_MAX)) ? DIR_W'(OUT_MAX) : DIR_W'(q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (adv) begin
         rv_ff <= dv_ff[QN];
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) ro_ff[i] <= ro_in[i];
      end
   end

   assign rsp_valid     = rv_ff;
   assign rsp_ray_dir_x = ro_ff[0];
   assign rsp_ray_dir_y = ro_ff[1];
   assign rsp_ray_dir_z = ro_ff[2];

endmodule

// ===== design/cprd_check.sv =====
// ----------------------------------------------------------------------------
// cprd_check: port-level checks for the camera primary ray block
// Watches the top level's handshakes and result range; bound to the top.
// ----------------------------------------------------------------------------
module cprd_check
   import cprd_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [DIR_W-1:0] rsp_ray_dir_x,
   input logic signed [DIR_W-1:0] rsp_ray_dir_y,
   input logic signed [DIR_W-1:0] rsp_ray_dir_z
);

   localparam int LIM_I = (FRAC_BITS < 17) ? (1 << FRAC_BITS) : OUT_MAX;
   localparam logic signed [DIR_W:0] LIM = (DIR_W+1)'(LIM_I);

   // no result item right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a waiting result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ray_dir_x)
         && $stable(rsp_ray_dir_y) && $stable(rsp_ray_dir_z))
      else $error("result item changed while stalled");

   // an empty result slot never blocks the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no result pending");

   // unit vector components never exceed one
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DIR_W+1)'(rsp_ray_dir_x) <= LIM && (DIR_W+1)'(rsp_ray_dir_x) >= -LIM
         && (DIR_W+1)'(rsp_ray_dir_y) <= LIM && (DIR_W+1)'(rsp_ray_dir_y) >= -LIM
         && (DIR_W+1)'(rsp_ray_dir_z) <= LIM && (DIR_W+1)'(rsp_ray_dir_z) >= -LIM)
      else $error("ray direction component out of unit range");

endmodule

bind camera_primary_ray_direction_top cprd_check #(.FRAC_BITS(FRAC_BITS)) u_cprd_check (.*);
